### rtl/lfu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lfu_pkg;

    localparam int unsigned FILE_W  = 16;
    localparam int unsigned BLOCK_W = 24;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned SLOT_W  = 4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } lfu_state_t;

    // control from the sequencer to the compare unit
    typedef struct packed {
        logic clear;
        logic step;
        logic first;
    } walk_ctl_t;

endpackage

`default_nettype wire

### rtl/lfu_walk.sv
`timescale 1ns / 1ps
`default_nettype none

module lfu_walk
    import lfu_pkg::*;
#(
    parameter int unsigned IDX_W = 4
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire walk_ctl_t         ctl,
    input  wire [IDX_W-1:0]        idx,
    input  wire                    entry_valid,
    input  wire [FILE_W-1:0]       entry_file,
    input  wire [BLOCK_W-1:0]      entry_block,
    input  wire [COUNT_W-1:0]      entry_count,
    input  wire [FILE_W-1:0]       req_file,
    input  wire [BLOCK_W-1:0]      req_block,
    output logic                   hit,
    output logic [IDX_W-1:0]       hit_idx,
    output logic [COUNT_W-1:0]     hit_count,
    output logic                   have_empty,
    output logic [IDX_W-1:0]       empty_idx,
    output logic [IDX_W-1:0]       min_idx
);

    logic               hit_reg, hit_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic [COUNT_W-1:0] hit_cnt_reg, hit_cnt_next;
    logic               empty_reg, empty_next;
    logic [IDX_W-1:0]   empty_idx_reg, empty_idx_next;
    logic [IDX_W-1:0]   min_idx_reg, min_idx_next;
    logic [COUNT_W-1:0] min_cnt_reg, min_cnt_next;
    logic               tag_match;
    logic               less;

    assign tag_match = entry_valid && (entry_file == req_file) && (entry_block == req_block);
    assign less      = entry_count < min_cnt_reg;

    always_comb
    begin
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_cnt_next   = hit_cnt_reg;
        empty_next     = empty_reg;
        empty_idx_next = empty_idx_reg;
        min_idx_next   = min_idx_reg;
        min_cnt_next   = min_cnt_reg;
        if (ctl.clear)
        begin
            hit_next   = 1'b0;
            empty_next = 1'b0;
        end
        else if (ctl.step)
        begin
            if (!hit_reg && tag_match)
            begin
                hit_next     = 1'b1;
                hit_idx_next = idx;
                hit_cnt_next = entry_count;
            end
            if (!entry_valid && !empty_reg)
            begin
                empty_next     = 1'b1;
                empty_idx_next = idx;
            end
            // strict less keeps the lowest index on ties
            if (ctl.first || less)
            begin
                min_idx_next = idx;
                min_cnt_next = entry_count;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg   <= 1'b0;
            empty_reg <= 1'b0;
        end
        else
        begin
            hit_reg   <= hit_next;
            empty_reg <= empty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_idx_reg   <= hit_idx_next;
        hit_cnt_reg   <= hit_cnt_next;
        empty_idx_reg <= empty_idx_next;
        min_idx_reg   <= min_idx_next;
        min_cnt_reg   <= min_cnt_next;
    end

    assign hit        = hit_reg;
    assign hit_idx    = hit_idx_reg;
    assign hit_count  = hit_cnt_reg;
    assign have_empty = empty_reg;
    assign empty_idx  = empty_idx_reg;
    assign min_idx    = min_idx_reg;

endmodule

`default_nettype wire

### rtl/lfu_block_cache_policy_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   signals                                      direction
// req       req_valid, req_ready, file_id, block_index    in
// rsp       rsp_valid, rsp_ready, hit, slot, evicted,     out
//           access_count
//
// a request beat is taken in the idle cycle; the walk then reads each slot in turn,
// one entry per cycle through a single read port with the compare unit taking each
// entry the cycle after its read, and the update state writes the chosen slot and
// loads the result register. a new request beat is taken only after the update,
// once the unit is back in idle, so requests do not overlap.
// reset empties every slot through the valid flops; tags and counts need no clearing.
// a result waiting on rsp_ready holds the update cycle; the next request is
// taken once the result register is loaded.

module lfu_block_cache_policy_unit
    import lfu_pkg::*;
#(
    parameter int unsigned NUM_SLOTS = 16
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 req_valid,
    output logic                req_ready,
    input  wire [FILE_W-1:0]    file_id,
    input  wire [BLOCK_W-1:0]   block_index,
    output logic                rsp_valid,
    input  wire                 rsp_ready,
    output logic                hit,
    output logic [SLOT_W-1:0]   slot,
    output logic                evicted,
    output logic [COUNT_W-1:0]  access_count
);

    localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int unsigned CNT_W = IDX_W + 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_SLOTS);

    lfu_state_t state_reg, state_next;

    logic [CNT_W-1:0]     rd_cnt_reg, rd_cnt_next;
    logic                 data_vld_reg;
    logic [IDX_W-1:0]     data_idx_reg;
    logic [FILE_W-1:0]    req_file_reg;
    logic [BLOCK_W-1:0]   req_block_reg;
    logic [NUM_SLOTS-1:0] slot_vld_reg;

    logic [FILE_W-1:0]    file_mem  [NUM_SLOTS];
    logic [BLOCK_W-1:0]   block_mem [NUM_SLOTS];
    logic [COUNT_W-1:0]   count_mem [NUM_SLOTS];
    logic [FILE_W-1:0]    rd_file_reg;
    logic [BLOCK_W-1:0]   rd_block_reg;
    logic [COUNT_W-1:0]   rd_count_reg;
    logic                 rd_vld_reg;

    logic                 rsp_valid_reg;
    logic                 hit_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic                 evicted_reg;
    logic [COUNT_W-1:0]   count_reg;

    walk_ctl_t            ctl;
    logic                 accept;
    logic                 issue;
    logic                 done;
    logic [IDX_W-1:0]     rd_addr;

    logic                 w_hit;
    logic [IDX_W-1:0]     w_hit_idx;
    logic [COUNT_W-1:0]   w_hit_count;
    logic                 w_have_empty;
    logic [IDX_W-1:0]     w_empty_idx;
    logic [IDX_W-1:0]     w_min_idx;

    logic [IDX_W-1:0]     chosen;
    logic [COUNT_W-1:0]   new_count;

    assign accept  = req_valid && req_ready;
    assign rd_addr = rd_cnt_reg[IDX_W-1:0];

    lfu_walk #(
        .IDX_W (IDX_W)
    ) u_walk (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .idx         (data_idx_reg),
        .entry_valid (rd_vld_reg),
        .entry_file  (rd_file_reg),
        .entry_block (rd_block_reg),
        .entry_count (rd_count_reg),
        .req_file    (req_file_reg),
        .req_block   (req_block_reg),
        .hit         (w_hit),
        .hit_idx     (w_hit_idx),
        .hit_count   (w_hit_count),
        .have_empty  (w_have_empty),
        .empty_idx   (w_empty_idx),
        .min_idx     (w_min_idx)
    );

    always_comb
    begin
        if (w_hit)
            chosen = w_hit_idx;
        else if (w_have_empty)
            chosen = w_empty_idx;
        else
            chosen = w_min_idx;
        // a miss restarts the count, so it lands on one
        if (!w_hit)
            new_count = COUNT_W'(1);
        else if (w_hit_count == COUNT_MAX)
            new_count = COUNT_MAX;
        else
            new_count = w_hit_count + COUNT_W'(1);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (rd_cnt_reg == LAST)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        req_ready = 1'b0;
        issue     = 1'b0;
        done      = 1'b0;
        ctl       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                ctl.clear = 1'b1;
            end
            ST_SCAN:
            begin
                issue     = (rd_cnt_reg != LAST);
                ctl.step  = data_vld_reg;
                ctl.first = (data_idx_reg == '0);
            end
            ST_UPDATE:
            begin
                done = !rsp_valid_reg || rsp_ready;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        rd_cnt_next = rd_cnt_reg;
        if (accept)
            rd_cnt_next = '0;
        else if (issue)
            rd_cnt_next = rd_cnt_reg + CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_cnt_reg    <= '0;
            data_vld_reg  <= 1'b0;
            slot_vld_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_cnt_reg   <= rd_cnt_next;
            data_vld_reg <= issue;
            if (done)
                slot_vld_reg[chosen] <= 1'b1;
            if (done)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_file_reg  <= file_id;
            req_block_reg <= block_index;
        end
        data_idx_reg <= rd_addr;
        if (issue)
            rd_vld_reg <= slot_vld_reg[rd_addr];
        if (done)
        begin
            hit_reg     <= w_hit;
            slot_reg    <= SLOT_W'(chosen);
            evicted_reg <= !w_hit && !w_have_empty;
            count_reg   <= new_count;
        end
    end

    // tag and count memories: one read port during the walk, one write at update
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_file_reg  <= file_mem[rd_addr];
            rd_block_reg <= block_mem[rd_addr];
            rd_count_reg <= count_mem[rd_addr];
        end
        if (done)
        begin
            count_mem[chosen] <= new_count;
            if (!w_hit)
            begin
                file_mem[chosen]  <= req_file_reg;
                block_mem[chosen] <= req_block_reg;
            end
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign hit          = hit_reg;
    assign slot         = slot_reg;
    assign evicted      = evicted_reg;
    assign access_count = count_reg;

    a_evict_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !w_hit && !w_have_empty) |-> (&slot_vld_reg))
        else $error("eviction chosen while an empty slot exists");

    a_hit_not_evicted: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(hit && evicted))
        else $error("hit flagged with eviction");

    a_miss_count_one: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !hit) |-> (access_count == COUNT_W'(1)))
        else $error("miss must restart the count at one");

    a_update_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> slot_vld_reg[$past(chosen)])
        else $error("updated slot not marked valid");

endmodule

`default_nettype wire
